// ===== sv/rar_pkg.sv =====
// Shared types and register indexes for the Rodrigues axis rotation block.
package rar_pkg;

   localparam int unsigned CoordW = 32;
   localparam int unsigned QW     = 16;
   localparam int unsigned CsrIdxW = 4;
   localparam int unsigned Latency = 7;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_ORIGIN_X  = 4'd0,
      CSR_ORIGIN_Y  = 4'd1,
      CSR_ORIGIN_Z  = 4'd2,
      CSR_AXIS_X    = 4'd3,
      CSR_AXIS_Y    = 4'd4,
      CSR_AXIS_Z    = 4'd5,
      CSR_COS_ANGLE = 4'd6,
      CSR_SIN_ANGLE = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic                     kind;
      logic signed [CoordW-1:0] in_x;
      logic signed [CoordW-1:0] in_y;
      logic signed [CoordW-1:0] in_z;
   } req_type;

   typedef struct packed {
      logic signed [CoordW-1:0] out_x;
      logic signed [CoordW-1:0] out_y;
      logic signed [CoordW-1:0] out_z;
      logic                     saturated;
   } rsp_type;

endpackage

// ===== sv/rodrigues_axis_rotation.sv =====
// Rodrigues axis rotation: seven-stage pipeline, one vector per clock.
//
// A transaction is taken at every clock edge with start high and busy low; busy is
// high only during reset. Each transaction's result appears on rsp_data with
// rsp_valid high for exactly one cycle, in order, once it has passed every pipeline
// stage; a new transaction may follow every cycle. The receiver cannot stall.
// The depth is set by the multiplier chain u*d -> dot*(1-c) -> w*d and the
// final 58-bit accumulate, round and saturate. Registers are written through
// csr_* (always ready); indexes above 7 are ignored. Registers must only
// change while no transaction is in flight.
module rodrigues_axis_rotation
   import rar_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CsrIdxW-1:0]   csr_index,
   input  logic [CoordW-1:0]    csr_wdata
);

   // configuration registers
   logic signed [CoordW-1:0] origin_ff [3];
   logic signed [QW-1:0]     axis_ff [3];
   logic signed [QW-1:0]     cos_ff;
   logic signed [QW-1:0]     sin_ff;

   assign csr_ready = 1'b1;
   assign busy      = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff[0] <= '0;
         origin_ff[1] <= '0;
         origin_ff[2] <= '0;
         axis_ff[0]   <= '0;
         axis_ff[1]   <= '0;
         axis_ff[2]   <= 16'sd16384;
         cos_ff       <= 16'sd16384;
         sin_ff       <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_ORIGIN_X:  origin_ff[0] <= csr_wdata;
            CSR_ORIGIN_Y:  origin_ff[1] <= csr_wdata;
            CSR_ORIGIN_Z:  origin_ff[2] <= csr_wdata;
            CSR_AXIS_X:    axis_ff[0]   <= csr_wdata[QW-1:0];
            CSR_AXIS_Y:    axis_ff[1]   <= csr_wdata[QW-1:0];
            CSR_AXIS_Z:    axis_ff[2]   <= csr_wdata[QW-1:0];
            CSR_COS_ANGLE: cos_ff       <= csr_wdata[QW-1:0];
            CSR_SIN_ANGLE: sin_ff       <= csr_wdata[QW-1:0];
            default: ;
         endcase
      end
   end

   // valid chain
   logic [Latency-1:0] vld_ff;
   logic               accept;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[Latency-2:0], accept};
      end
   end

   // origin travels with the transaction (zero for a direction)
   logic signed [CoordW-1:0] o1_ff [3], o2_ff [3], o3_ff [3], o4_ff [3];
   logic signed [CoordW-1:0] o5_ff [3], o6_ff [3];

   // stage 1: offset removal
   logic signed [32:0] u_ff [3];
   logic signed [32:0] u_in [3];
   logic signed [CoordW-1:0] o_in [3];
   logic signed [CoordW-1:0] v_in [3];

   assign v_in[0] = req_data.in_x;
   assign v_in[1] = req_data.in_y;
   assign v_in[2] = req_data.in_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         o_in[i] = req_data.kind ? '0 : origin_ff[i];
         u_in[i] = 33'(v_in[i]) - 33'(o_in[i]);
      end
   end

   // stage 2: all d_j*u_k products and u*c
   logic signed [48:0] p_ff [3][3];
   logic signed [48:0] uc_ff [3];

   // stage 3: dot and cross, rounded
   logic signed [50:0] dot_sum;
   logic signed [36:0] dot_ff;
   logic signed [49:0] cr_sum [3];
   logic signed [35:0] cr_ff [3];
   logic signed [48:0] uc3_ff [3];

   assign dot_sum = 51'(p_ff[0][0]) + 51'(p_ff[1][1]) + 51'(p_ff[2][2]) + 51'sd8192;
   assign cr_sum[0] = 50'(p_ff[1][2]) - 50'(p_ff[2][1]) + 50'sd8192;
   assign cr_sum[1] = 50'(p_ff[2][0]) - 50'(p_ff[0][2]) + 50'sd8192;
   assign cr_sum[2] = 50'(p_ff[0][1]) - 50'(p_ff[1][0]) + 50'sd8192;

   // stage 4: dot*(1-c) and cross*s
   logic signed [16:0] omc;
   logic signed [53:0] wp_ff;
   logic signed [51:0] xs_ff [3];
   logic signed [48:0] uc4_ff [3];

   assign omc = 17'sd16384 - 17'(cos_ff);

   // stage 5: round w, w*d
   logic signed [53:0] w_sum;
   logic signed [39:0] w_rnd;
   logic signed [55:0] wd_ff [3];
   logic signed [51:0] xs5_ff [3];
   logic signed [48:0] uc5_ff [3];

   assign w_sum = wp_ff + 54'sd8192;
   assign w_rnd = w_sum[53:14];

   // stage 6: accumulate and round
   logic signed [57:0] acc [3];
   logic signed [43:0] r_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i] = 58'(uc5_ff[i]) + 58'(wd_ff[i]) + 58'(xs5_ff[i]) + 58'sd8192;
      end
   end

   // stage 7: origin restore and saturation
   logic signed [44:0] fin [3];
   logic [2:0]         clip;
   logic signed [CoordW-1:0] sat_val [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fin[i]  = 45'(r_ff[i]) + 45'(o6_ff[i]);
         clip[i] = !((&fin[i][44:31]) || !(|fin[i][44:31]));
         if (!clip[i]) begin
            sat_val[i] = fin[i][31:0];
         end else if (fin[i][44]) begin
            sat_val[i] = {1'b1, {(CoordW-1){1'b0}}};
         end else begin
            sat_val[i] = {1'b0, {(CoordW-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         u_ff[i]  <= u_in[i];
         o1_ff[i] <= o_in[i];
         for (int k = 0; k < 3; k++) begin
            p_ff[i][k] <= axis_ff[i] * u_ff[k];
         end
         uc_ff[i]  <= u_ff[i] * cos_ff;
         o2_ff[i]  <= o1_ff[i];
         cr_ff[i]  <= cr_sum[i][49:14];
         uc3_ff[i] <= uc_ff[i];
         o3_ff[i]  <= o2_ff[i];
         xs_ff[i]  <= cr_ff[i] * sin_ff;
         uc4_ff[i] <= uc3_ff[i];
         o4_ff[i]  <= o3_ff[i];
         wd_ff[i]  <= w_rnd * axis_ff[i];
         xs5_ff[i] <= xs_ff[i];
         uc5_ff[i] <= uc4_ff[i];
         o5_ff[i]  <= o4_ff[i];
         r_ff[i]   <= acc[i][57:14];
         o6_ff[i]  <= o5_ff[i];
      end
      dot_ff <= dot_sum[50:14];
      wp_ff  <= dot_ff * omc;
      rsp_data.out_x     <= sat_val[0];
      rsp_data.out_y     <= sat_val[1];
      rsp_data.out_z     <= sat_val[2];
      rsp_data.saturated <= |clip;
   end

   assign rsp_valid = vld_ff[Latency-1];

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##Latency rsp_valid)
      else $error("accepted transaction without result strobe");

   a_no_stray: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, Latency))
      else $error("result strobe without accepted transaction");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe after reset");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.saturated) |->
         (rsp_data.out_x == 32'sh7fffffff || rsp_data.out_x == 32'sh80000000 ||
          rsp_data.out_y == 32'sh7fffffff || rsp_data.out_y == 32'sh80000000 ||
          rsp_data.out_z == 32'sh7fffffff || rsp_data.out_z == 32'sh80000000))
      else $error("saturation flag without clipped component");

endmodule
